/* rtl/gbn_pkg.sv */
// ----------------------------------------------------------------------------
// Go-Back-N send window package
// Shared payload types, register indexes, event codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package gbn_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 10;

  localparam int unsigned TIMEOUT_W = 20;
  localparam int unsigned RETRY_W   = 8;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd20000;
  localparam logic [RETRY_W-1:0]   RETRY_RESET   = 8'd5;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY   = 1'b1;

  // Input opcodes.
  localparam logic [1:0] OPC_ENQ  = 2'd0;
  localparam logic [1:0] OPC_ACK  = 2'd1;
  localparam logic [1:0] OPC_TICK = 2'd2;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_TRANSMIT  = 3'd0,
    EV_RETX      = 3'd1,
    EV_REJECT    = 3'd2,
    EV_ACK_OK    = 3'd3,
    EV_ACK_IGN   = 3'd4,
    EV_TICK_IDLE = 3'd5
  } ev_e;

  // Classified item kind handed from the front to the back.
  typedef enum logic [1:0] {
    K_ENQ,
    K_ACK,
    K_TICK,
    K_NONE
  } kind_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] channel;
    logic [30:0] seq_num;
    logic [31:0] buffer_ref;
    logic [15:0] byte_len;
    logic        ack_flag;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [15:0] channel_out;
    logic [30:0] seq_out;
    logic [31:0] buffer_out;
    logic [15:0] len_out;
    logic [3:0]  window_fill;
    logic        gave_up;
    logic        last;
  } out_t;

  // One descriptor of the send window.
  typedef struct packed {
    logic [30:0] seq;
    logic [31:0] buf_ref;
    logic [15:0] chan;
    logic [15:0] len;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    kind_e kind;
    in_t   data;
  } item_t;

endpackage

`default_nettype wire

/* rtl/go_back_n_send_window_top.sv */
// ----------------------------------------------------------------------------
// Go-Back-N send window
// Sender window of packet descriptors with acknowledgment and retransmission.
// ----------------------------------------------------------------------------
// Input beats carry an enqueue, an ack or a tick. The output channel gives one
// result beat per item, except a timeout, which gives one retransmit beat per
// outstanding descriptor in ring order with last set on the final one. Both
// channels use valid and stall; a beat moves when valid is high and stall low.
// A two-entry queue sits behind the input, so items are taken while the back
// end is busy or the output is stalled.
// An enqueue, a tick and an ignored ack finish in the idle state of the back
// end; an ack that is compared against the head waits in the compare state
// for the registered read of the descriptor RAM; a timeout walks the ring in
// the retransmit state. Each item passes the input queue and output register.
// A stalled output beat is held; the back end then waits and the input queue
// fills before the input stalls.
// Reset empties the window and the queue, clears both counters and loads the
// timeout and retry limit registers with their defaults; the user writes the
// configuration on the write port only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module go_back_n_send_window_top #(
  parameter int unsigned WINDOW_DEPTH = gbn_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [gbn_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire gbn_pkg::in_t                    in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output gbn_pkg::out_t                        out_data_o
);

  logic           q_valid;
  logic           q_pop;
  gbn_pkg::item_t q_item;

  gbn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  gbn_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // The back end never takes an item from an empty queue.
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // Only a timeout retransmission carries the give-up flag.
  a_gave_up_on_retx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.gave_up |->
      out_data_o.event_kind == gbn_pkg::EV_RETX)
    else $error("gave_up set on a result that is not a retransmit");

  // A rejected enqueue is only reported with the window full.
  a_reject_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (WINDOW_DEPTH < 16) && out_valid_o &&
      out_data_o.event_kind == gbn_pkg::EV_REJECT |->
      out_data_o.window_fill == 4'(WINDOW_DEPTH))
    else $error("enqueue rejected with room in the window");

  // A retransmit only happens with packets outstanding.
  a_retx_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (WINDOW_DEPTH < 16) && out_valid_o &&
      out_data_o.event_kind == gbn_pkg::EV_RETX |->
      out_data_o.window_fill != 4'd0)
    else $error("retransmit reported on an empty window");

endmodule

`default_nettype wire

/* rtl/gbn_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/gbn_front.sv */
// ----------------------------------------------------------------------------
// Go-Back-N front end
// Accepts input beats, classifies the opcode and holds up to two items.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire gbn_pkg::in_t  in_data_i,
  output logic               q_valid_o,
  output gbn_pkg::item_t     q_item_o,
  input  wire logic          q_pop_i
);

  gbn_pkg::item_t slot_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push;
  gbn_pkg::item_t item_new;

  function automatic gbn_pkg::kind_e classify(input logic [1:0] opc);
    gbn_pkg::kind_e k;
    unique case (opc)
      gbn_pkg::OPC_ENQ:  k = gbn_pkg::K_ENQ;
      gbn_pkg::OPC_ACK:  k = gbn_pkg::K_ACK;
      gbn_pkg::OPC_TICK: k = gbn_pkg::K_TICK;
      default:           k = gbn_pkg::K_NONE;
    endcase
    return k;
  endfunction

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];

  always_comb begin
    item_new.kind = classify(in_data_i.opcode);
    item_new.data = in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

`default_nettype wire

/* rtl/gbn_back.sv */
// ----------------------------------------------------------------------------
// Go-Back-N back end
// Holds the descriptor ring, the timers and the output register, and
// carries out enqueue, ack and tick items one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_back #(
  parameter int unsigned WINDOW_DEPTH = gbn_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [gbn_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            q_valid_i,
  input  wire gbn_pkg::item_t                  q_item_i,
  output logic                                 q_pop_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output gbn_pkg::out_t                        out_data_o
);

  localparam int unsigned IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned OW = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACK_CMP,
    ST_RTX
  } state_e;

  state_e                           state_q, state_d;
  logic [IW-1:0]                    head_q, head_d;
  logic [IW-1:0]                    tail_q, tail_d;
  logic [OW-1:0]                    occ_q, occ_d;
  logic [gbn_pkg::TIMEOUT_W-1:0]    tcnt_q, tcnt_d;
  logic [gbn_pkg::RETRY_W-1:0]      retry_q, retry_d;
  logic [gbn_pkg::TIMEOUT_W-1:0]    timeout_q, timeout_d;
  logic [gbn_pkg::RETRY_W-1:0]      retry_lim_q, retry_lim_d;
  logic [IW-1:0]                    walk_idx_q, walk_idx_d;
  logic [OW-1:0]                    walk_cnt_q, walk_cnt_d;
  logic                             gave_q, gave_d;
  logic [30:0]                      ack_seq_q, ack_seq_d;
  logic                             out_valid_q, out_valid_d;
  gbn_pkg::out_t                    out_q, out_d;

  logic                             out_free;
  logic                             ram_we, ram_re;
  logic [IW-1:0]                    ram_waddr, ram_raddr;
  gbn_pkg::entry_t                  ram_wentry, ram_rentry;
  logic [gbn_pkg::ENTRY_W-1:0]      ram_rdata;
  logic [gbn_pkg::TIMEOUT_W-1:0]    tcnt_inc;
  logic [gbn_pkg::RETRY_W-1:0]      retry_inc;
  logic                             walk_last;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx);
    logic [IW-1:0] n;
    if (idx == IW'(WINDOW_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = idx + IW'(1);
    end
    return n;
  endfunction

  gbn_ram #(
    .WIDTH (gbn_pkg::ENTRY_W),
    .DEPTH (WINDOW_DEPTH),
    .AW    (IW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wentry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_rentry  = ram_rdata;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign tcnt_inc    = tcnt_q + gbn_pkg::TIMEOUT_W'(1);
  assign retry_inc   = retry_q + gbn_pkg::RETRY_W'(1);
  assign walk_last   = (walk_cnt_q == occ_q - OW'(1));
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    tcnt_d      = tcnt_q;
    retry_d     = retry_q;
    timeout_d   = timeout_q;
    retry_lim_d = retry_lim_q;
    walk_idx_d  = walk_idx_q;
    walk_cnt_d  = walk_cnt_q;
    gave_d      = gave_q;
    ack_seq_d   = ack_seq_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = tail_q;
    ram_raddr   = head_q;
    ram_wentry.seq     = q_item_i.data.seq_num;
    ram_wentry.buf_ref = q_item_i.data.buffer_ref;
    ram_wentry.chan    = q_item_i.data.channel;
    ram_wentry.len     = q_item_i.data.byte_len;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gbn_pkg::CFG_TIMEOUT: timeout_d   = cfg_data_i[gbn_pkg::TIMEOUT_W-1:0];
        gbn_pkg::CFG_RETRY:   retry_lim_d = cfg_data_i[gbn_pkg::RETRY_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o     = 1'b1;
          out_d       = '0;
          out_d.last  = 1'b1;
          out_d.window_fill = 4'(occ_q);
          unique case (q_item_i.kind)
            gbn_pkg::K_ENQ: begin
              out_valid_d   = 1'b1;
              out_d.seq_out = q_item_i.data.seq_num;
              if (occ_q == OW'(WINDOW_DEPTH)) begin
                out_d.event_kind = gbn_pkg::EV_REJECT;
              end else begin
                ram_we            = 1'b1;
                tail_d            = next_idx(tail_q);
                occ_d             = occ_q + OW'(1);
                out_d.event_kind  = gbn_pkg::EV_TRANSMIT;
                out_d.channel_out = q_item_i.data.channel;
                out_d.buffer_out  = q_item_i.data.buffer_ref;
                out_d.len_out     = q_item_i.data.byte_len;
                out_d.window_fill = 4'(occ_q + OW'(1));
              end
            end
            gbn_pkg::K_ACK: begin
              if (occ_q != '0 && q_item_i.data.ack_flag) begin
                // The head descriptor is read now and compared in the compare state once the output is free.
                ram_re    = 1'b1;
                ack_seq_d = q_item_i.data.seq_num;
                state_d   = ST_ACK_CMP;
              end else begin
                out_valid_d      = 1'b1;
                out_d.event_kind = gbn_pkg::EV_ACK_IGN;
                out_d.seq_out    = q_item_i.data.seq_num;
              end
            end
            gbn_pkg::K_TICK: begin
              if (occ_q != '0 && tcnt_inc >= timeout_q) begin
                tcnt_d = '0;
                if (retry_inc >= retry_lim_q) begin
                  gave_d  = 1'b1;
                  retry_d = '0;
                end else begin
                  gave_d  = 1'b0;
                  retry_d = retry_inc;
                end
                ram_re     = 1'b1;
                walk_idx_d = head_q;
                walk_cnt_d = '0;
                state_d    = ST_RTX;
              end else begin
                if (occ_q != '0) begin
                  tcnt_d = tcnt_inc;
                end
                out_valid_d      = 1'b1;
                out_d.event_kind = gbn_pkg::EV_TICK_IDLE;
              end
            end
            default: begin
              out_valid_d      = 1'b1;
              out_d.event_kind = gbn_pkg::EV_TICK_IDLE;
            end
          endcase
        end
      end

      ST_ACK_CMP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.last  = 1'b1;
          state_d     = ST_IDLE;
          if (ram_rentry.seq == ack_seq_q) begin
            head_d            = next_idx(head_q);
            occ_d             = occ_q - OW'(1);
            tcnt_d            = '0;
            retry_d           = '0;
            out_d.event_kind  = gbn_pkg::EV_ACK_OK;
            out_d.channel_out = ram_rentry.chan;
            out_d.seq_out     = ram_rentry.seq;
            out_d.buffer_out  = ram_rentry.buf_ref;
            out_d.len_out     = ram_rentry.len;
            out_d.window_fill = 4'(occ_q - OW'(1));
          end else begin
            out_d.event_kind  = gbn_pkg::EV_ACK_IGN;
            out_d.seq_out     = ack_seq_q;
            out_d.window_fill = 4'(occ_q);
          end
        end
      end

      ST_RTX: begin
        // One descriptor per beat; the next read is issued as this one leaves.
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.event_kind  = gbn_pkg::EV_RETX;
          out_d.channel_out = ram_rentry.chan;
          out_d.seq_out     = ram_rentry.seq;
          out_d.buffer_out  = ram_rentry.buf_ref;
          out_d.len_out     = ram_rentry.len;
          out_d.window_fill = 4'(occ_q);
          out_d.gave_up     = gave_q;
          out_d.last        = walk_last;
          if (walk_last) begin
            state_d = ST_IDLE;
          end else begin
            walk_idx_d = next_idx(walk_idx_q);
            walk_cnt_d = walk_cnt_q + OW'(1);
            ram_re     = 1'b1;
            ram_raddr  = next_idx(walk_idx_q);
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      tcnt_q      <= '0;
      retry_q     <= '0;
      timeout_q   <= gbn_pkg::TIMEOUT_RESET;
      retry_lim_q <= gbn_pkg::RETRY_RESET;
      walk_idx_q  <= '0;
      walk_cnt_q  <= '0;
      gave_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      tcnt_q      <= tcnt_d;
      retry_q     <= retry_d;
      timeout_q   <= timeout_d;
      retry_lim_q <= retry_lim_d;
      walk_idx_q  <= walk_idx_d;
      walk_cnt_q  <= walk_cnt_d;
      gave_q      <= gave_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ack_seq_q <= ack_seq_d;
    out_q     <= out_d;
  end

endmodule

`default_nettype wire
